// ===== rtl/sha256_pkg.sv =====
// ----------------------------------------------------------------------------
// sha256_pkg
// constants, types and round functions shared by the stream hasher
// ----------------------------------------------------------------------------
package sha256_pkg;

    localparam int unsigned BlockBytes = 64;
    localparam int unsigned LenPos     = 56;
    localparam logic [7:0]  PadByte    = 8'h80;

    typedef logic [31:0] t_word;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } t_in_req;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_req;

    function automatic t_word init_h(input logic [2:0] idx);
        case (idx)
            3'd0:    init_h = 32'h6a09e667;
            3'd1:    init_h = 32'hbb67ae85;
            3'd2:    init_h = 32'h3c6ef372;
            3'd3:    init_h = 32'ha54ff53a;
            3'd4:    init_h = 32'h510e527f;
            3'd5:    init_h = 32'h9b05688c;
            3'd6:    init_h = 32'h1f83d9ab;
            default: init_h = 32'h5be0cd19;
        endcase
    endfunction

    function automatic t_word round_k(input logic [5:0] idx);
        t_word k [64];
        k = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
            32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
            32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
            32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
            32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
            32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
            32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
            32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
            32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
        };
        round_k = k[idx];
    endfunction

    function automatic t_word rotr(input t_word x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ===== rtl/sha256_if.sv =====
// ----------------------------------------------------------------------------
// sha256_in_if / sha256_out_if
// valid/ready channels for byte requests and digest words
// ----------------------------------------------------------------------------
interface sha256_in_if;
    logic                      valid;
    logic                      ready;
    sha256_pkg::t_in_req       payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface sha256_out_if;
    logic                      valid;
    logic                      ready;
    sha256_pkg::t_out_req      payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/sha256_round.sv =====
// ----------------------------------------------------------------------------
// sha256_round
// shared compression unit: schedule window and working registers, one round
// per cycle, then chaining-word update
// ----------------------------------------------------------------------------
module sha256_round (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic                     i_load_word,
    input  sha256_pkg::t_word        i_word,
    input  logic                     i_clear_chain,
    input  logic [2:0]               i_rd_idx,
    output sha256_pkg::t_word        o_rd_word,
    output logic                     o_busy
);

    sha256_pkg::t_word r_w [16];
    sha256_pkg::t_word r_v [8];
    sha256_pkg::t_word r_h [8];
    logic [5:0]        r_round;
    logic              r_busy;
    logic              r_fin;

    sha256_pkg::t_word s0, s1, w_new, w_cur, t1, t2, e, a;

    always_comb begin
        w_cur = r_w[0];
        s0 = sha256_pkg::rotr(r_w[1], 7) ^ sha256_pkg::rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        s1 = sha256_pkg::rotr(r_w[14], 17) ^ sha256_pkg::rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        w_new = r_w[0] + s0 + r_w[9] + s1;
        e = r_v[4];
        a = r_v[0];
        t1 = r_v[7] + (sha256_pkg::rotr(e, 6) ^ sha256_pkg::rotr(e, 11)
             ^ sha256_pkg::rotr(e, 25)) + ((e & r_v[5]) ^ (~e & r_v[6]))
             + sha256_pkg::round_k(r_round) + w_cur;
        t2 = (sha256_pkg::rotr(a, 2) ^ sha256_pkg::rotr(a, 13) ^ sha256_pkg::rotr(a, 22))
             + ((a & r_v[1]) ^ (a & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_fin   <= 1'b0;
            r_round <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= sha256_pkg::init_h(3'(i));
        end else begin
            r_fin <= 1'b0;
            if (i_clear_chain) begin
                for (int i = 0; i < 8; i++) r_h[i] <= sha256_pkg::init_h(3'(i));
            end
            if (i_load_word) begin
                for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                r_w[15] <= i_word;
            end
            if (i_start) begin
                r_busy  <= 1'b1;
                r_round <= '0;
                for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
            end else if (r_busy) begin
                for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                r_w[15] <= w_new;
                r_v[7] <= r_v[6];
                r_v[6] <= r_v[5];
                r_v[5] <= r_v[4];
                r_v[4] <= r_v[3] + t1;
                r_v[3] <= r_v[2];
                r_v[2] <= r_v[1];
                r_v[1] <= r_v[0];
                r_v[0] <= t1 + t2;
                r_round <= r_round + 6'd1;
                if (r_round == 6'd63) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
            end
        end
    end

    assign o_rd_word = r_h[i_rd_idx];
    assign o_busy    = r_busy | r_fin | i_start;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_start) else $error("compression restarted while busy");
    a_fin_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_round == 6'd63 && !i_start) |=> r_fin) else $error("missed finish");
    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_load_word) else $error("word loaded during rounds");

endmodule

// ===== rtl/sha256_stream_hasher_core.sv =====
// ----------------------------------------------------------------------------
// sha256_stream_hasher_core
// byte-stream SHA-256: packs bytes into words, pads and emits the digest
// ----------------------------------------------------------------------------
// channel   dir  fields
// i_in      in   data_byte, byte_valid, end_of_message
// o_out     out  digest_word, word_index, last_word
//
// a byte is taken when ready; one that completes a word pushes it into the
// schedule window and holds ready low while it loads; the 64th also holds
// ready low through the start, the rounds and the update on the shared round
// unit
// end of message: padding words loaded one at a time, one or two compressions,
// then eight digest requests, each held until taken
// i_rst_n is synchronous, active low; ready is low while the unit works
// ----------------------------------------------------------------------------
module sha256_stream_hasher_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    sha256_in_if.sink          i_in,
    sha256_out_if.source       o_out
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_WAIT, ST_PAD, ST_PAD_WAIT, ST_EMIT
    } t_state;

    t_state      r_state;
    logic [6:0]  r_fill;
    logic [60:0] r_msg;
    logic [23:0] r_acc;
    logic        r_pad_byte;
    logic        r_second;
    logic [2:0]  r_idx;
    logic        r_out_valid;
    logic        r_load;
    logic        r_start;
    logic        r_clear;
    sha256_pkg::t_word r_word;

    logic        unit_busy;
    sha256_pkg::t_word rd_word;
    logic [63:0] bits;
    logic        accept;

    assign bits   = {r_msg, 3'b000};
    assign accept = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == ST_IDLE) && !unit_busy && !r_load;

    sha256_round u_round (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (r_start),
        .i_load_word  (r_load),
        .i_word       (r_word),
        .i_clear_chain(r_clear),
        .i_rd_idx     (r_idx),
        .o_rd_word    (rd_word),
        .o_busy       (unit_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_msg       <= '0;
            r_pad_byte  <= 1'b0;
            r_second    <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
            r_load      <= 1'b0;
            r_start     <= 1'b0;
            r_clear     <= 1'b0;
        end else begin
            r_load  <= 1'b0;
            r_start <= 1'b0;
            r_clear <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        if (i_in.payload.byte_valid) begin
                            r_msg  <= r_msg + 61'd1;
                            r_fill <= (r_fill == 7'd63) ? 7'd0 : r_fill + 7'd1;
                            if (r_fill[1:0] == 2'd3) begin
                                r_word <= {r_acc, i_in.payload.data_byte};
                                r_load <= 1'b1;
                            end else begin
                                r_acc <= {r_acc[15:0], i_in.payload.data_byte};
                            end
                            if (r_fill == 7'd63) r_start <= 1'b1;
                        end
                        if (i_in.payload.end_of_message) begin
                            r_pad_byte <= 1'b1;
                            r_second   <= 1'b0;
                            r_state    <= (i_in.payload.byte_valid && r_fill == 7'd63)
                                          ? ST_WAIT : ST_PAD;
                        end
                    end
                end
                ST_WAIT: begin
                    if (!unit_busy && !r_start) r_state <= ST_PAD;
                end
                ST_PAD: begin
                    if (!unit_busy && !r_start && !r_load) begin
                        // length words once past the pad, else finish current word with pad and zero bytes
                        if (r_fill >= 7'(sha256_pkg::LenPos) && r_fill[1:0] == 2'd0
                            && !r_pad_byte && !r_second) begin
                            r_word <= (r_fill == 7'd56) ? bits[63:32] : bits[31:0];
                            r_load <= 1'b1;
                            if (r_fill == 7'd60) begin
                                r_fill  <= '0;
                                r_start <= 1'b1;
                                r_state <= ST_PAD_WAIT;
                            end else begin
                                r_fill <= r_fill + 7'd4;
                            end
                        end else begin
                            unique case (r_fill[1:0])
                                2'd0: r_word <= {r_pad_byte ? sha256_pkg::PadByte : 8'h00,
                                                 24'h0};
                                2'd1: r_word <= {r_acc[7:0],
                                                 r_pad_byte ? sha256_pkg::PadByte : 8'h00,
                                                 16'h0};
                                2'd2: r_word <= {r_acc[15:0],
                                                 r_pad_byte ? sha256_pkg::PadByte : 8'h00,
                                                 8'h0};
                                default: r_word <= {r_acc[23:0],
                                                    r_pad_byte ? sha256_pkg::PadByte : 8'h00};
                            endcase
                            r_load     <= 1'b1;
                            r_pad_byte <= 1'b0;
                            r_acc      <= '0;
                            if ({r_fill[6:2], 2'b00} == 7'd60) begin
                                r_fill   <= '0;
                                r_start  <= 1'b1;
                                r_second <= 1'b1;
                                r_state  <= ST_PAD_WAIT;
                            end else begin
                                r_fill <= {r_fill[6:2], 2'b00} + 7'd4;
                                // pad byte at or past the length field position needs an extra block
                                if (r_pad_byte && r_fill >= 7'(sha256_pkg::LenPos))
                                    r_second <= 1'b1;
                            end
                        end
                    end
                end
                ST_PAD_WAIT: begin
                    if (!unit_busy && !r_start) begin
                        if (r_second) begin
                            r_second <= 1'b0;
                            r_state  <= ST_PAD;
                        end else begin
                            r_idx       <= '0;
                            r_out_valid <= 1'b1;
                            r_state     <= ST_EMIT;
                        end
                    end
                end
                ST_EMIT: begin
                    if (o_out.ready) begin
                        if (r_idx == 3'd7) begin
                            r_out_valid <= 1'b0;
                            r_msg       <= '0;
                            r_fill      <= '0;
                            r_clear     <= 1'b1;
                            r_idx       <= '0;
                            r_state     <= ST_IDLE;
                        end else begin
                            r_idx <= r_idx + 3'd1;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out.valid               = r_out_valid;
    assign o_out.payload.digest_word = rd_word;
    assign o_out.payload.word_index  = r_idx;
    assign o_out.payload.last_word   = (r_idx == 3'd7);

    a_no_in_during_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !i_in.ready) else $error("input open while emitting");
    a_emit_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_state == ST_EMIT)) else $error("output valid outside emit");
    a_clear_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && r_idx == 3'd7) |=> r_clear)
        else $error("chain not cleared after digest");

endmodule
